/* rtl/ssrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrr_pkg
// Shared types and constants of the special-register read unit.
// ----------------------------------------------------------------------------
package ssrr_pkg;

  localparam int LANES_DEF       = 32;
  localparam int BLOCK_SLOTS_DEF = 16;
  localparam int MAX_WARPS       = 64;

  localparam int DIM_XY_W   = 11;
  localparam int DIM_Z_W    = 7;
  localparam int WPB_W      = 6;
  localparam int DVS_W      = 2 * DIM_XY_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;
  localparam int QDEPTH     = 2;
  localparam int QA_W       = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  localparam logic [CFG_IDX_W-1:0] CFG_DIM_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DIM_Z = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WPB   = 2'd3;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [2:0] SEL_TID_X  = 3'd0;
  localparam logic [2:0] SEL_TID_Y  = 3'd1;
  localparam logic [2:0] SEL_TID_Z  = 3'd2;
  localparam logic [2:0] SEL_CTA_X  = 3'd3;
  localparam logic [2:0] SEL_CTA_Y  = 3'd4;
  localparam logic [2:0] SEL_CTA_Z  = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_REG  = 2'd1;
  localparam logic [1:0] ST_BAD_SLOT = 2'd2;

  typedef enum logic [1:0] {
    K_LOAD,
    K_READ,
    K_BAD_REG,
    K_BAD_SLOT
  } kind_t;

  typedef struct packed {
    logic        op;
    logic [3:0]  slot;
    logic [30:0] block_id_x;
    logic [15:0] block_id_y;
    logic [15:0] block_id_z;
    logic [5:0]  warp;
    logic [4:0]  lane;
    logic [2:0]  reg_select;
  } in_item_t;

  typedef struct packed {
    logic [30:0] value;
    logic [1:0]  status;
  } out_result_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  slot;
    logic [30:0] bx;
    logic [15:0] by;
    logic [15:0] bz;
    logic [5:0]  warp;
    logic [4:0]  lane;
    logic [2:0]  sel;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

  typedef struct packed {
    logic [DIM_XY_W-1:0] dim_x;
    logic [DIM_XY_W-1:0] dim_y;
    logic [DIM_Z_W-1:0]  dim_z;
    logic [WPB_W-1:0]    wpb;
  } cfg_t;

  typedef struct packed {
    logic [30:0] bx;
    logic [15:0] by;
    logic [15:0] bz;
  } slot_ids_t;

endpackage

/* rtl/ssrr_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ssrr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/ssrr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrr_div
// Iterative restoring divider, two quotient bits per cycle.
// ----------------------------------------------------------------------------
module ssrr_div #(
  parameter int DIV_W = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DIV_W-1:0]         dividend,
  input  logic [ssrr_pkg::DVS_W-1:0] divisor,
  output logic                     done,
  output logic [DIV_W-1:0]         quo,
  output logic [DIV_W-1:0]         rem
);

  localparam int DVS_W = ssrr_pkg::DVS_W;
  localparam int STEPS = DIV_W / 2;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DIV_W-1:0] qd_r, qd_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;

  logic [DVS_W:0]   sh_a, rem_a, sh_b, rem_b;
  logic [DIV_W-1:0] qd_a, qd_b;
  logic             ge_a, ge_b;

  // two restoring steps
  always_comb begin
    sh_a  = {rem_r[DVS_W-1:0], qd_r[DIV_W-1]};
    ge_a  = sh_a >= {1'b0, dvs_r};
    rem_a = ge_a ? (sh_a - {1'b0, dvs_r}) : sh_a;
    qd_a  = {qd_r[DIV_W-2:0], ge_a};
    sh_b  = {rem_a[DVS_W-1:0], qd_a[DIV_W-1]};
    ge_b  = sh_b >= {1'b0, dvs_r};
    rem_b = ge_b ? (sh_b - {1'b0, dvs_r}) : sh_b;
    qd_b  = {qd_a[DIV_W-2:0], ge_b};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    qd_nxt   = qd_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(STEPS);
      rem_nxt  = '0;
      qd_nxt   = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      rem_nxt = rem_b;
      qd_nxt  = qd_b;
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    qd_r  <= qd_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = qd_r;
  assign rem  = rem_r[DIV_W-1:0];

endmodule

/* rtl/ssrr_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrr_front
// Accepts items, sorts them by kind and queues them for the back end; loads to an out-of-range slot are dropped.
// ----------------------------------------------------------------------------
module ssrr_front #(
  parameter int BLOCK_SLOTS = ssrr_pkg::BLOCK_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  ssrr_pkg::in_item_t     in_item,
  input  logic                   pop,
  output logic                   busy,
  output ssrr_pkg::queue_head_t  head
);

  localparam int QDEPTH = ssrr_pkg::QDEPTH;
  localparam int QA_W   = ssrr_pkg::QA_W;
  localparam int QC_W   = $clog2(QDEPTH + 1);

  ssrr_pkg::entry_t mem_r [QDEPTH];
  logic [QA_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QA_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QC_W-1:0]  cnt_r, cnt_nxt;

  ssrr_pkg::entry_t entry;
  logic             accept;
  logic             push;
  logic             load_ok;

  // classify
  always_comb begin
    load_ok     = 32'(in_item.slot) < 32'(BLOCK_SLOTS);
    entry.slot  = in_item.slot;
    entry.bx    = in_item.block_id_x;
    entry.by    = in_item.block_id_y;
    entry.bz    = in_item.block_id_z;
    entry.warp  = in_item.warp;
    entry.lane  = in_item.lane;
    entry.sel   = in_item.reg_select;
    if (in_item.op == ssrr_pkg::OP_LOAD) begin
      entry.kind = ssrr_pkg::K_LOAD;
    end else if (in_item.reg_select > ssrr_pkg::SEL_CTA_Z) begin
      entry.kind = ssrr_pkg::K_BAD_REG;
    end else if (32'(in_item.warp) >= 32'(ssrr_pkg::MAX_WARPS)) begin
      entry.kind = ssrr_pkg::K_BAD_SLOT;
    end else begin
      entry.kind = ssrr_pkg::K_READ;
    end
  end

  assign busy   = (cnt_r == QC_W'(QDEPTH));
  assign accept = start && !busy;
  // out-of-range loads are dropped here
  assign push   = accept && ((in_item.op == ssrr_pkg::OP_READ) || load_ok);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QA_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QA_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QA_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QA_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + QC_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - QC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  assign head.valid = (cnt_r != '0);
  assign head.entry = mem_r[rd_ptr_r];

endmodule

/* rtl/ssrr_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssrr_back
// Executes queued items: slot table writes, index divisions, table reads, error results.
// ----------------------------------------------------------------------------
module ssrr_back #(
  parameter int LANES       = ssrr_pkg::LANES_DEF,
  parameter int BLOCK_SLOTS = ssrr_pkg::BLOCK_SLOTS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  ssrr_pkg::cfg_t         cfg,
  input  ssrr_pkg::queue_head_t  head,
  output logic                   pop,
  output logic                   out_valid,
  output ssrr_pkg::out_result_t  out_result
);

  localparam int IDX_W   = $clog2(64 * LANES + 32);
  localparam int DIV_W   = IDX_W + (IDX_W % 2);
  localparam int DVS_W   = ssrr_pkg::DVS_W;
  localparam int XY_W    = ssrr_pkg::DIM_XY_W;
  localparam int WPB_W   = ssrr_pkg::WPB_W;
  localparam int SLOT_AW = (BLOCK_SLOTS > 1) ? $clog2(BLOCK_SLOTS) : 1;
  localparam int WORD_W  = $bits(ssrr_pkg::slot_ids_t);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SLOT,
    S_MEM,
    S_DIV_A,
    S_DIV_B
  } state_t;

  state_t                state_r, state_nxt;
  ssrr_pkg::entry_t      item_r, item_nxt;
  logic                  out_valid_r, out_valid_nxt;
  ssrr_pkg::out_result_t out_result_r, out_result_nxt;
  logic [DVS_W-1:0]      dxy_r, dxy_nxt;

  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic [DVS_W-1:0]      div_divisor;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quo;
  logic [DIV_W-1:0]      div_rem;

  logic                  ram_we;
  logic [SLOT_AW-1:0]    ram_waddr;
  ssrr_pkg::slot_ids_t   ram_wdata;
  logic [SLOT_AW-1:0]    ram_raddr;
  logic [WORD_W-1:0]     ram_rdata;
  ssrr_pkg::slot_ids_t   rd_ids;

  logic [XY_W-1:0]       dx, dy;
  logic [ssrr_pkg::DIM_Z_W-1:0] dz;
  logic [WPB_W-1:0]      wpb;
  logic [IDX_W-1:0]      idx;
  logic                  slot_ok;

  // zero dimensions act as one
  assign dx  = (cfg.dim_x == '0) ? XY_W'(1) : cfg.dim_x;
  assign dy  = (cfg.dim_y == '0) ? XY_W'(1) : cfg.dim_y;
  assign dz  = (cfg.dim_z == '0) ? ssrr_pkg::DIM_Z_W'(1) : cfg.dim_z;
  assign wpb = (cfg.wpb == '0) ? WPB_W'(1) : cfg.wpb;

  assign dxy_nxt = DVS_W'(dx) * DVS_W'(dy);
  assign idx     = IDX_W'(IDX_W'(div_rem[WPB_W-1:0]) * IDX_W'(LANES))
                   + IDX_W'(item_r.lane);
  assign slot_ok = 32'(div_quo) < 32'(BLOCK_SLOTS);
  assign rd_ids  = ssrr_pkg::slot_ids_t'(ram_rdata);

  assign ram_waddr    = SLOT_AW'(head.entry.slot);
  assign ram_wdata.bx = head.entry.bx;
  assign ram_wdata.by = head.entry.by;
  assign ram_wdata.bz = head.entry.bz;
  assign ram_raddr    = SLOT_AW'(div_quo);

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    pop            = 1'b0;
    ram_we         = 1'b0;
    div_start      = 1'b0;
    div_dividend   = DIV_W'(head.entry.warp);
    div_divisor    = DVS_W'(wpb);
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          item_nxt = head.entry;
          unique case (head.entry.kind)
            ssrr_pkg::K_LOAD: begin
              ram_we = 1'b1;
            end
            ssrr_pkg::K_BAD_REG: begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.value  = '0;
              out_result_nxt.status = ssrr_pkg::ST_BAD_REG;
            end
            ssrr_pkg::K_BAD_SLOT: begin
              out_valid_nxt         = 1'b1;
              out_result_nxt.value  = '0;
              out_result_nxt.status = ssrr_pkg::ST_BAD_SLOT;
            end
            ssrr_pkg::K_READ: begin
              div_start = 1'b1;
              state_nxt = S_SLOT;
            end
          endcase
        end
      end
      S_SLOT: begin
        if (div_done) begin
          if (!slot_ok) begin
            out_valid_nxt         = 1'b1;
            out_result_nxt.value  = '0;
            out_result_nxt.status = ssrr_pkg::ST_BAD_SLOT;
            state_nxt             = S_IDLE;
          end else if (item_r.sel >= ssrr_pkg::SEL_CTA_X) begin
            state_nxt = S_MEM;
          end else begin
            div_start    = 1'b1;
            div_dividend = DIV_W'(idx);
            div_divisor  = (item_r.sel == ssrr_pkg::SEL_TID_Z) ? dxy_r : DVS_W'(dx);
            state_nxt    = S_DIV_A;
          end
        end
      end
      S_MEM: begin
        out_valid_nxt         = 1'b1;
        out_result_nxt.status = ssrr_pkg::ST_OK;
        unique case (item_r.sel)
          ssrr_pkg::SEL_CTA_X: out_result_nxt.value = rd_ids.bx;
          ssrr_pkg::SEL_CTA_Y: out_result_nxt.value = 31'(rd_ids.by);
          default:             out_result_nxt.value = 31'(rd_ids.bz);
        endcase
        state_nxt = S_IDLE;
      end
      S_DIV_A: begin
        if (div_done) begin
          if (item_r.sel == ssrr_pkg::SEL_TID_X) begin
            out_valid_nxt         = 1'b1;
            out_result_nxt.value  = 31'(div_rem);
            out_result_nxt.status = ssrr_pkg::ST_OK;
            state_nxt             = S_IDLE;
          end else begin
            div_start    = 1'b1;
            div_dividend = div_quo;
            div_divisor  = (item_r.sel == ssrr_pkg::SEL_TID_Y) ? DVS_W'(dy) : DVS_W'(dz);
            state_nxt    = S_DIV_B;
          end
        end
      end
      S_DIV_B: begin
        if (div_done) begin
          out_valid_nxt         = 1'b1;
          out_result_nxt.value  = 31'(div_rem);
          out_result_nxt.status = ssrr_pkg::ST_OK;
          state_nxt             = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r       <= item_nxt;
    out_result_r <= out_result_nxt;
    dxy_r        <= dxy_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  ssrr_div #(
    .DIV_W (DIV_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  ssrr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (BLOCK_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

/* rtl/simt_special_register_read.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simt_special_register_read
// Special-register read unit: thread index and block id of a warp's lane.
// ----------------------------------------------------------------------------
// Items enter on start when busy is low and wait in a two-entry queue; busy
// is high only while that queue is full. A load is written to the slot table
// as it leaves the queue and gives no result. A read of an invalid register or
// of an out-of-range warp is answered from the result register as it leaves
// the queue. Other reads first divide the warp by warps_per_block in the
// shared radix-4 divider, which is IDX_W bits wide rounded up to even, with
// IDX_W = clog2(64*LANES+32), so 12 with 32 lanes. A slot out of range then
// answers as soon as that division is done, a block id read goes on to the
// slot RAM, tid.x takes one more divider pass and tid.y or tid.z two. Every
// result also waits behind earlier items in the queue. Each result appears
// for exactly one cycle on out_valid and must be taken then; the receiver
// cannot hold it off.
// ----------------------------------------------------------------------------
module simt_special_register_read #(
  parameter int LANES       = ssrr_pkg::LANES_DEF,
  parameter int BLOCK_SLOTS = ssrr_pkg::BLOCK_SLOTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  ssrr_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  output ssrr_pkg::out_result_t              out_result,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssrr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssrr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  ssrr_pkg::cfg_t        cfg_r, cfg_nxt;
  ssrr_pkg::queue_head_t head;
  logic                  pop;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssrr_pkg::CFG_DIM_X: cfg_nxt.dim_x = cfg_data[ssrr_pkg::DIM_XY_W-1:0];
        ssrr_pkg::CFG_DIM_Y: cfg_nxt.dim_y = cfg_data[ssrr_pkg::DIM_XY_W-1:0];
        ssrr_pkg::CFG_DIM_Z: cfg_nxt.dim_z = cfg_data[ssrr_pkg::DIM_Z_W-1:0];
        ssrr_pkg::CFG_WPB:   cfg_nxt.wpb   = cfg_data[ssrr_pkg::WPB_W-1:0];
        default:             cfg_nxt       = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dim_x <= ssrr_pkg::DIM_XY_W'(1);
      cfg_r.dim_y <= ssrr_pkg::DIM_XY_W'(1);
      cfg_r.dim_z <= ssrr_pkg::DIM_Z_W'(1);
      cfg_r.wpb   <= ssrr_pkg::WPB_W'(1);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  ssrr_front #(
    .BLOCK_SLOTS (BLOCK_SLOTS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_item (in_item),
    .pop     (pop),
    .busy    (busy),
    .head    (head)
  );

  ssrr_back #(
    .LANES       (LANES),
    .BLOCK_SLOTS (BLOCK_SLOTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

`ifndef ASSERT_OFF
  // error transfers carry a zero value
  a_err_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result.status != ssrr_pkg::ST_OK)) |-> (out_result.value == '0))
    else $error("error result with nonzero value");

  // only defined status codes leave the block
  a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_result.status == ssrr_pkg::ST_OK) ||
                   (out_result.status == ssrr_pkg::ST_BAD_REG) ||
                   (out_result.status == ssrr_pkg::ST_BAD_SLOT)))
    else $error("undefined status code");

  // reset empties the queue and clears the result strobe
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> (!busy && !out_valid))
    else $error("busy or result after reset");
`endif

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the special-register read unit. Slot loads and
// register reads go in through the start/busy port while a shadow copy of the
// slot table and block geometry predicts every thread index and block id
// value. Results are compared field by field in order. Runs through several
// block shapes, extremes and zero registers, with and without input gaps.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LANE_COUNT = ssrr_pkg::LANES_DEF;
  localparam int SLOT_COUNT = ssrr_pkg::BLOCK_SLOTS_DEF;
  localparam int SETTLE     = 40;
  localparam int STALL_MAX  = 4000;
  localparam int GAP_MAX    = 60;
  localparam int PHASE_LEN  = 100;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            start = 1'b0;
  logic                            busy;
  ssrr_pkg::in_item_t              in_item = '0;
  logic                            out_valid;
  ssrr_pkg::out_result_t           out_result;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [ssrr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssrr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  simt_special_register_read uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_valid  (out_valid),
    .out_result (out_result),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // shadow geometry and slot table
  logic [ssrr_pkg::DIM_XY_W-1:0] dim_x_r = ssrr_pkg::DIM_XY_W'(1);
  logic [ssrr_pkg::DIM_XY_W-1:0] dim_y_r = ssrr_pkg::DIM_XY_W'(1);
  logic [ssrr_pkg::DIM_Z_W-1:0]  dim_z_r = ssrr_pkg::DIM_Z_W'(1);
  logic [ssrr_pkg::WPB_W-1:0]    wpb_r   = ssrr_pkg::WPB_W'(1);
  logic [30:0]                   cta_x [SLOT_COUNT];
  logic [15:0]                   cta_y [SLOT_COUNT];
  logic [15:0]                   cta_z [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]         loaded = '0;

  ssrr_pkg::out_result_t sreg_queue[$];

  int errors = 0;
  int idle_pct = 0;
  int n_loads = 0;
  int n_reads = 0;
  int n_bad_reg = 0;
  int n_bad_slot = 0;
  int n_cfg = 0;
  int stall = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic ssrr_pkg::out_result_t sreg_value(ssrr_pkg::in_item_t it);
    int unsigned wpb, dx, dy, dz, slot, idx;
    ssrr_pkg::out_result_t r;
    wpb = (wpb_r == 0) ? 1 : wpb_r;
    dx = (dim_x_r == 0) ? 1 : dim_x_r;
    dy = (dim_y_r == 0) ? 1 : dim_y_r;
    dz = (dim_z_r == 0) ? 1 : dim_z_r;
    slot = it.warp / wpb;
    idx = (it.warp % wpb) * LANE_COUNT + it.lane;
    r = '0;
    if (it.reg_select > ssrr_pkg::SEL_CTA_Z) begin
      r.status = ssrr_pkg::ST_BAD_REG;
    end else if (it.warp >= ssrr_pkg::MAX_WARPS || slot >= SLOT_COUNT) begin
      r.status = ssrr_pkg::ST_BAD_SLOT;
    end else begin
      r.status = ssrr_pkg::ST_OK;
      unique case (it.reg_select)
        ssrr_pkg::SEL_TID_X: r.value = 31'(idx % dx);
        ssrr_pkg::SEL_TID_Y: r.value = 31'((idx / dx) % dy);
        ssrr_pkg::SEL_TID_Z: r.value = 31'((idx / (dx * dy)) % dz);
        ssrr_pkg::SEL_CTA_X: r.value = cta_x[slot];
        ssrr_pkg::SEL_CTA_Y: r.value = 31'(cta_y[slot]);
        default:             r.value = 31'(cta_z[slot]);
      endcase
    end
    return r;
  endfunction

  // bookkeeping for one accepted transfer
  function automatic void take_item(ssrr_pkg::in_item_t it);
    ssrr_pkg::out_result_t r;
    if (it.op == ssrr_pkg::OP_LOAD) begin
      cta_x[it.slot] = it.block_id_x;
      cta_y[it.slot] = it.block_id_y;
      cta_z[it.slot] = it.block_id_z;
      loaded[it.slot] = 1'b1;
      n_loads++;
    end else begin
      r = sreg_value(it);
      sreg_queue = {sreg_queue, r};
      n_reads++;
      if (r.status == ssrr_pkg::ST_BAD_REG) n_bad_reg++;
      if (r.status == ssrr_pkg::ST_BAD_SLOT) n_bad_slot++;
    end
  endfunction

  function automatic ssrr_pkg::in_item_t load_item(input logic [3:0] slot,
                                                   input logic [30:0] bx,
                                                   input logic [15:0] by,
                                                   input logic [15:0] bz);
    ssrr_pkg::in_item_t it;
    it = '0;
    it.op = ssrr_pkg::OP_LOAD;
    it.slot = slot;
    it.block_id_x = bx;
    it.block_id_y = by;
    it.block_id_z = bz;
    return it;
  endfunction

  function automatic ssrr_pkg::in_item_t read_item(input logic [5:0] warp,
                                                   input logic [4:0] lane,
                                                   input logic [2:0] sel);
    ssrr_pkg::in_item_t it;
    it = '0;
    it.op = ssrr_pkg::OP_READ;
    it.warp = warp;
    it.lane = lane;
    it.reg_select = sel;
    return it;
  endfunction

  function automatic ssrr_pkg::in_item_t rand_item(input bit is_load);
    ssrr_pkg::in_item_t it;
    int unsigned wpb, slot;
    it.op = is_load ? ssrr_pkg::OP_LOAD : ssrr_pkg::OP_READ;
    it.slot = 4'($urandom);
    it.block_id_x = 31'($urandom);
    it.block_id_y = 16'($urandom);
    it.block_id_z = 16'($urandom);
    it.warp = 6'($urandom);
    it.lane = 5'($urandom);
    if ($urandom_range(0, 99) < 12) it.reg_select = 3'($urandom_range(6, 7));
    else it.reg_select = 3'($urandom_range(0, 5));
    // block id reads of an in-range slot only once that slot is loaded
    wpb = (wpb_r == 0) ? 1 : wpb_r;
    slot = it.warp / wpb;
    if (!is_load && it.reg_select >= ssrr_pkg::SEL_CTA_X &&
        it.reg_select <= ssrr_pkg::SEL_CTA_Z &&
        slot < SLOT_COUNT && !loaded[slot]) begin
      it.reg_select = ssrr_pkg::SEL_TID_X;
    end
    return it;
  endfunction

  function automatic int pick_gap();
    int gap;
    gap = 0;
    while (idle_pct > 0 && gap < GAP_MAX && $urandom_range(0, 99) < idle_pct) gap++;
    return gap;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got 0x%0h want 0x%0h at %0t", what, got, want, $time);
  endtask

  // start stays high when the next item follows without a gap
  task automatic send_item(input ssrr_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy);
    take_item(it);
  endtask

  task automatic quiet();
    @(negedge clk);
    start <= 1'b0;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    quiet();
    while (sreg_queue.size() != 0) @(posedge clk);
    // loads give no result and may still be in flight
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ssrr_pkg::CFG_IDX_W-1:0] idx,
                           input logic [31:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[ssrr_pkg::CFG_DATA_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    unique case (idx)
      ssrr_pkg::CFG_DIM_X: dim_x_r = data[ssrr_pkg::DIM_XY_W-1:0];
      ssrr_pkg::CFG_DIM_Y: dim_y_r = data[ssrr_pkg::DIM_XY_W-1:0];
      ssrr_pkg::CFG_DIM_Z: dim_z_r = data[ssrr_pkg::DIM_Z_W-1:0];
      default:             wpb_r = data[ssrr_pkg::WPB_W-1:0];
    endcase
    n_cfg++;
  endtask

  task automatic set_shape(input int unsigned dx, input int unsigned dy,
                           input int unsigned dz, input int unsigned wpb);
    drain();
    write_reg(ssrr_pkg::CFG_DIM_X, dx);
    write_reg(ssrr_pkg::CFG_DIM_Y, dy);
    write_reg(ssrr_pkg::CFG_DIM_Z, dz);
    write_reg(ssrr_pkg::CFG_WPB, wpb);
    quiet();
  endtask

  task automatic run_traffic(input int count);
    repeat (count) send_item(rand_item($urandom_range(0, 99) < 25));
  endtask

  task automatic test_directed_reads();
    idle_pct = 0;
    set_shape(4, 2, 8, 2);
    send_item(load_item(4'd0, 31'h7fff_ffff, 16'hffff, 16'hffff));
    send_item(load_item(4'd15, 31'd0, 16'd0, 16'd0));
    send_item(load_item(4'd1, 31'h2aaa_5555, 16'h5a5a, 16'ha5a5));
    for (int s = ssrr_pkg::SEL_TID_X; s <= ssrr_pkg::SEL_CTA_Z; s++) begin
      send_item(read_item(6'd0, 5'd0, 3'(s)));
    end
    send_item(read_item(6'd1, 5'd31, ssrr_pkg::SEL_TID_X));
    send_item(read_item(6'd1, 5'd31, ssrr_pkg::SEL_TID_Y));
    send_item(read_item(6'd1, 5'd31, ssrr_pkg::SEL_TID_Z));
    send_item(read_item(6'd31, 5'd31, ssrr_pkg::SEL_CTA_Z));
    send_item(read_item(6'd30, 5'd17, ssrr_pkg::SEL_CTA_X));
    send_item(read_item(6'd2, 5'd3, ssrr_pkg::SEL_CTA_Y));
    // invalid register wins over an out-of-range slot
    send_item(read_item(6'd63, 5'd31, 3'd6));
    send_item(read_item(6'd0, 5'd0, 3'd7));
    send_item(read_item(6'd63, 5'd31, ssrr_pkg::SEL_CTA_X));
    send_item(read_item(6'd32, 5'd0, ssrr_pkg::SEL_TID_X));
  endtask

  task automatic test_register_sweep();
    int unsigned shapes [6][4];
    shapes = '{'{1, 1, 1, 1}, '{1024, 1024, 64, 32}, '{0, 0, 0, 0},
               '{2047, 2047, 127, 63}, '{3, 5, 7, 4}, '{32, 32, 1, 32}};
    for (int p = 0; p < 6; p++) begin
      set_shape(shapes[p][0], shapes[p][1], shapes[p][2], shapes[p][3]);
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 71 : 11;
      run_traffic(PHASE_LEN);
    end
  endtask

  task automatic test_random_traffic();
    for (int p = 0; p < 6; p++) begin
      set_shape($urandom_range(1, 40), $urandom_range(1, 12), $urandom_range(1, 10),
                $urandom_range(1, 32));
      idle_pct = (p % 3 == 0) ? 71 : (p % 3 == 1) ? 11 : 0;
      run_traffic(PHASE_LEN);
    end
  endtask

  task automatic test_drain_pause();
    set_shape(5, 3, 4, 3);
    idle_pct = 0;
    run_traffic(20);
    // hold the sender until every pending read has answered
    quiet();
    while (sreg_queue.size() != 0) @(posedge clk);
    run_traffic(20);
  endtask

  // result checker: every strobe is a transfer
  always @(posedge clk) begin
    ssrr_pkg::out_result_t want;
    if (rst_n && out_valid) begin
      if (sreg_queue.size() == 0) begin
        report_mismatch("result with nothing pending", 32'(out_result), 32'd0);
      end else begin
        want = sreg_queue.pop_front();
        if (out_result.value !== want.value)
          report_mismatch("value", 32'(out_result.value), 32'(want.value));
        if (out_result.status !== want.status)
          report_mismatch("status", 32'(out_result.status), 32'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall <= 0;
    end else if (stall >= STALL_MAX) begin
      $display("watchdog: no transfer for %0d cycles", STALL_MAX);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall <= stall + 1;
    end
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_reads();
    test_register_sweep();
    test_random_traffic();
    test_drain_pause();
    drain();
    $display("covered %0d slot loads, %0d reads, %0d config writes", n_loads, n_reads, n_cfg);
    $display("reads with invalid register %0d, with slot out of range %0d",
             n_bad_reg, n_bad_slot);
    if (errors == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/ssrr_pkg.sv
rtl/ssrr_ram.sv
rtl/ssrr_div.sv
rtl/ssrr_front.sv
rtl/ssrr_back.sv
rtl/simt_special_register_read.sv
tb/testbench.sv
